// File: design/ehp_pkg.sv
// Shared types and constants for the Ethernet/IPv4 header parser.
// Used by the capture, queue, summary and top-level modules; no dependencies.
package ehp_pkg;

   localparam int DEFAULT_MAX_FRAME_BYTES = 16384;
   localparam int DEFAULT_QUEUE_DEPTH     = 4;

   localparam int LEN_W = 16;  // holds any frame count up to the largest frame limit
   localparam int CMP_W = 17;  // offsets and counts compared without overflow

   // register indexes on the CSR port
   localparam logic [1:0] CSR_LINK_OFFSET = 2'd0;
   localparam logic [1:0] CSR_HTTP_ENABLE = 2'd1;
   localparam logic [1:0] CSR_TLS_ENABLE  = 2'd2;

   localparam logic [6:0] RESET_LINK_OFFSET = 7'd14;

   // packet classes
   localparam logic [2:0] CLASS_NONIP = 3'd0;
   localparam logic [2:0] CLASS_TCP   = 3'd1;
   localparam logic [2:0] CLASS_UDP   = 3'd2;
   localparam logic [2:0] CLASS_ICMP  = 3'd3;
   localparam logic [2:0] CLASS_OTHER = 3'd4;
   localparam logic [2:0] CLASS_HTTP  = 3'd5;
   localparam logic [2:0] CLASS_TLS   = 3'd6;

   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [3:0]  IP_VERSION_4 = 4'd4;
   localparam logic [15:0] PORT_HTTP  = 16'd80;
   localparam logic [15:0] PORT_TLS   = 16'd443;

   localparam int ETH_HEADER_BYTES = 14;
   localparam int IP_MIN_BYTES     = 20;
   localparam int TCP_MIN_BYTES    = 20;
   localparam int UDP_HEADER_BYTES = 8;

   typedef struct packed {
      logic [6:0] link_offset;
      logic       http_enable;
      logic       tls_enable;
   } cfg_type;

   // header fields captured over one frame
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [47:0]      dest_mac;
      logic [47:0]      source_mac;
      logic [3:0]       ip_version;
      logic [3:0]       ip_header_words;
      logic [7:0]       ip_protocol;
      logic [7:0]       ttl;
      logic [31:0]      source_ip;
      logic [31:0]      dest_ip;
      logic [15:0]      source_port;
      logic [15:0]      dest_port;
      logic [15:0]      udp_length;
      logic [3:0]       tcp_header_words;
      logic [4:0]       flags;
   } frame_type;

   typedef struct packed {
      logic        status;
      logic [2:0]  packet_class;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [7:0]  time_to_live;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [4:0]  tcp_flag_bits;
      logic [15:0] payload_length;
      logic [14:0] frame_length;
   } result_type;

endpackage

// File: design/ehp_capture.sv
// Front end: latches header fields by byte position as the frame streams past.
// Depends on ehp_pkg; hands a completed frame record to the queue on the last byte.
module ehp_capture import ehp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic [6:0] link_offset,
   output logic       frame_push,
   output frame_type  frame_out
);

   frame_type        frame_ff, frame_in;
   logic [CMP_W-1:0] pos, off, l4;
   logic [3:0]       ihl_now;
   logic             capture_en;

   assign pos        = CMP_W'(frame_ff.len);
   assign off        = CMP_W'(link_offset);
   assign capture_en = frame_ff.len < LEN_W'(MAX_FRAME_BYTES);
   assign ihl_now    = (pos == off) ? data_byte[3:0] : frame_ff.ip_header_words;
   assign l4         = off + CMP_W'({ihl_now, 2'b00});

   always_comb begin
      frame_in = frame_ff;
      if (capture_en) begin
         if (pos < CMP_W'(6))
            frame_in.dest_mac = {frame_ff.dest_mac[39:0], data_byte};
         else if (pos < CMP_W'(12))
            frame_in.source_mac = {frame_ff.source_mac[39:0], data_byte};
         if (pos == off) begin
            frame_in.ip_version      = data_byte[7:4];
            frame_in.ip_header_words = data_byte[3:0];
         end
         if (pos == off + CMP_W'(8))
            frame_in.ttl = data_byte;
         if (pos == off + CMP_W'(9))
            frame_in.ip_protocol = data_byte;
         if (pos >= off + CMP_W'(12) && pos < off + CMP_W'(16))
            frame_in.source_ip = {frame_ff.source_ip[23:0], data_byte};
         if (pos >= off + CMP_W'(16) && pos < off + CMP_W'(20))
            frame_in.dest_ip = {frame_ff.dest_ip[23:0], data_byte};
         if (pos >= l4 && pos < l4 + CMP_W'(2))
            frame_in.source_port = {frame_ff.source_port[7:0], data_byte};
         if (pos >= l4 + CMP_W'(2) && pos < l4 + CMP_W'(4))
            frame_in.dest_port = {frame_ff.dest_port[7:0], data_byte};
         if (pos >= l4 + CMP_W'(4) && pos < l4 + CMP_W'(6))
            frame_in.udp_length = {frame_ff.udp_length[7:0], data_byte};
         if (pos == l4 + CMP_W'(12))
            frame_in.tcp_header_words = data_byte[7:4];
         // reorder wire flags (FIN SYN RST PSH ACK) into SYN ACK FIN RST PSH
         if (pos == l4 + CMP_W'(13))
            frame_in.flags = {data_byte[3], data_byte[2], data_byte[0],
                              data_byte[4], data_byte[1]};
         frame_in.len = frame_ff.len + LEN_W'(1);
      end
   end

   assign frame_push = accept && last_byte;
   assign frame_out  = frame_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (accept) begin
         // drop the per-frame state once the record is handed on
         frame_ff <= last_byte ? '0 : frame_in;
      end
   end

endmodule

// File: design/ehp_queue.sv
// Short queue of completed frame records between capture and summary.
// Depends on ehp_pkg for the record type.
module ehp_queue import ehp_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output frame_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   frame_type       mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]   count_ff;
   logic            do_push, do_pop;

   assign full    = count_ff == NW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push)
         mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         if (do_push && !do_pop)
            count_ff <= count_ff + NW'(1);
         else if (do_pop && !do_push)
            count_ff <= count_ff - NW'(1);
      end
   end

endmodule

// File: design/ehp_summary.sv
// Back end: turns a frame record into the summary and holds it for the consumer.
// Depends on ehp_pkg for the record, result and configuration types.
module ehp_summary import ehp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       frame_empty,
   input  frame_type  frame,
   input  cfg_type    cfg,
   output logic       frame_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output result_type rsp
);

   result_type       result_in, rsp_ff;
   logic             valid_ff;
   logic [CMP_W-1:0] len, off, l4, pay_start;
   logic             is_http, is_tls;

   assign len       = CMP_W'(frame.len);
   assign off       = CMP_W'(cfg.link_offset);
   assign l4        = off + CMP_W'({frame.ip_header_words, 2'b00});
   assign pay_start = l4 + CMP_W'({frame.tcp_header_words, 2'b00});
   assign is_http   = frame.source_port == PORT_HTTP || frame.dest_port == PORT_HTTP;
   assign is_tls    = frame.source_port == PORT_TLS || frame.dest_port == PORT_TLS;

   always_comb begin
      result_in = '0;
      result_in.frame_length = frame.len[14:0];
      if (len < CMP_W'(ETH_HEADER_BYTES) || len < off + CMP_W'(IP_MIN_BYTES)) begin
         result_in.status = 1'b1;
      end else if (frame.ip_version != IP_VERSION_4) begin
         result_in.packet_class = CLASS_NONIP;
         if (off >= CMP_W'(ETH_HEADER_BYTES)) begin
            result_in.dest_mac   = frame.dest_mac;
            result_in.source_mac = frame.source_mac;
         end
      end else if ((frame.ip_protocol == PROTO_TCP && len < l4 + CMP_W'(TCP_MIN_BYTES)) ||
                   (frame.ip_protocol == PROTO_UDP && len < l4 + CMP_W'(UDP_HEADER_BYTES)))
      begin
         result_in.status = 1'b1;
      end else begin
         if (off >= CMP_W'(ETH_HEADER_BYTES)) begin
            result_in.dest_mac   = frame.dest_mac;
            result_in.source_mac = frame.source_mac;
         end
         result_in.source_ip    = frame.source_ip;
         result_in.dest_ip      = frame.dest_ip;
         result_in.time_to_live = frame.ttl;
         case (frame.ip_protocol)
            PROTO_TCP: begin
               result_in.packet_class = CLASS_TCP;
               if (is_http) begin
                  if (cfg.http_enable)
                     result_in.packet_class = CLASS_HTTP;
               end else if (is_tls && cfg.tls_enable) begin
                  result_in.packet_class = CLASS_TLS;
               end
               result_in.source_port   = frame.source_port;
               result_in.dest_port     = frame.dest_port;
               result_in.tcp_flag_bits = frame.flags;
               if (len > pay_start)
                  result_in.payload_length = 16'(len - pay_start);
            end
            PROTO_UDP: begin
               result_in.packet_class = CLASS_UDP;
               result_in.source_port  = frame.source_port;
               result_in.dest_port    = frame.dest_port;
               if (frame.udp_length > 16'(UDP_HEADER_BYTES))
                  result_in.payload_length = frame.udp_length - 16'(UDP_HEADER_BYTES);
            end
            PROTO_ICMP: result_in.packet_class = CLASS_ICMP;
            default:    result_in.packet_class = CLASS_OTHER;
         endcase
      end
   end

   // advance the queue whenever the output slot is free or being emptied
   assign frame_pop = !frame_empty && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (frame_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop)
         rsp_ff <= result_in;
   end

endmodule

// File: design/ethernet_ipv4_header_parser.sv
// Ethernet/IPv4/TCP/UDP header parser, one frame byte per cycle.
// Throughput: one byte every cycle while the frame queue has room; set by the capture stage.
// Path: the record enters the frame queue at the edge that takes the last byte, then loads
// the output register once the output slot is free or being emptied.
// Reset (synchronous): registers return to link offset 14 with HTTP and TLS enabled,
// frame state clears and the queue and output register empty.
module ethernet_ipv4_header_parser import ehp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES,
   parameter int QUEUE_DEPTH     = DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_status,
   output logic [2:0]  rsp_packet_class,
   output logic [47:0] rsp_dest_mac,
   output logic [47:0] rsp_source_mac,
   output logic [31:0] rsp_source_ip,
   output logic [31:0] rsp_dest_ip,
   output logic [7:0]  rsp_time_to_live,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [4:0]  rsp_tcp_flag_bits,
   output logic [15:0] rsp_payload_length,
   output logic [14:0] rsp_frame_length,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   cfg_type    cfg_ff;
   frame_type  frame_rec, frame_head;
   result_type rsp;
   logic       accept, frame_push, frame_pop, frame_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_offset <= RESET_LINK_OFFSET;
         cfg_ff.http_enable <= 1'b1;
         cfg_ff.tls_enable  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINK_OFFSET: cfg_ff.link_offset <= csr_wdata;
            CSR_HTTP_ENABLE: cfg_ff.http_enable <= csr_wdata[0];
            CSR_TLS_ENABLE:  cfg_ff.tls_enable  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign accept = req_push && !req_full;

   ehp_capture #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .link_offset(cfg_ff.link_offset),
      .frame_push (frame_push),
      .frame_out  (frame_rec)
   );

   ehp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (frame_push),
      .push_data(frame_rec),
      .pop      (frame_pop),
      .full     (req_full),
      .empty    (frame_empty),
      .head     (frame_head)
   );

   ehp_summary u_summary (
      .clock      (clock),
      .reset      (reset),
      .frame_empty(frame_empty),
      .frame      (frame_head),
      .cfg        (cfg_ff),
      .frame_pop  (frame_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_packet_class   = rsp.packet_class;
   assign rsp_dest_mac       = rsp.dest_mac;
   assign rsp_source_mac     = rsp.source_mac;
   assign rsp_source_ip      = rsp.source_ip;
   assign rsp_dest_ip        = rsp.dest_ip;
   assign rsp_time_to_live   = rsp.time_to_live;
   assign rsp_source_port    = rsp.source_port;
   assign rsp_dest_port      = rsp.dest_port;
   assign rsp_tcp_flag_bits  = rsp.tcp_flag_bits;
   assign rsp_payload_length = rsp.payload_length;
   assign rsp_frame_length   = rsp.frame_length;

endmodule
